FILE: rtl/aep_pkg.sv
package aep_pkg;

    localparam int POSITIONS_DEF    = 512;
    localparam int COUNTER_BITS_DEF = 32;

    localparam logic [7:0] GAP_CHAR = 8'd45;
    localparam logic [7:0] CHAR_A   = 8'd65;
    localparam logic [7:0] CHAR_C   = 8'd67;
    localparam logic [7:0] CHAR_G   = 8'd71;
    localparam logic [7:0] CHAR_T   = 8'd84;
    localparam logic [7:0] CASE_BIT = 8'd32;

    localparam logic [9:0] COLUMN_MAX = 10'd1023;

    // Register reset values
    localparam logic       ALIGNED_MODE_RST = 1'b1;
    localparam logic [9:0] POS_LIMIT_RST    = 10'd500;
    localparam logic [7:0] LOW_BOUND_RST    = 8'd10;
    localparam logic [7:0] HIGH_BOUND_RST   = 8'd30;

    localparam logic OP_COLUMN = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Quality bins
    localparam logic [1:0] BIN_LOW      = 2'd0;
    localparam logic [1:0] BIN_MIDDLE   = 2'd1;
    localparam logic [1:0] BIN_HIGH     = 2'd2;
    localparam logic [1:0] BIN_UNMAPPED = 2'd3;

    // Counter kinds as requested on the input channel
    localparam logic [3:0] KIND_MIS_A     = 4'd0;
    localparam logic [3:0] KIND_MIS_C     = 4'd1;
    localparam logic [3:0] KIND_MIS_G     = 4'd2;
    localparam logic [3:0] KIND_MIS_T     = 4'd3;
    localparam logic [3:0] KIND_MIS_OTHER = 4'd4;
    localparam logic [3:0] KIND_INS       = 4'd5;
    localparam logic [3:0] KIND_DEL       = 4'd6;
    localparam logic [3:0] KIND_TOT_MIS   = 4'd7;
    localparam logic [3:0] KIND_TOT_INS   = 4'd8;
    localparam logic [3:0] KIND_TOT_DEL   = 4'd9;

    // Slot of a total within its group
    localparam logic [1:0] TOT_MIS = 2'd0;
    localparam logic [1:0] TOT_INS = 2'd1;
    localparam logic [1:0] TOT_DEL = 2'd2;

    localparam int TOT_AW = 5;

    typedef enum logic [1:0] {
        REG_ALIGNED_MODE = 2'd0,
        REG_POS_LIMIT    = 2'd1,
        REG_LOW_BOUND    = 2'd2,
        REG_HIGH_BOUND   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_POS  = 2'd1,
        SEL_TOT  = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    vld;
        logic    rd;
        logic    pos_en;
        logic    tot_en;
        rd_sel_t sel;
    } req_t;

    function automatic logic [2:0] base_class(input logic [7:0] ch);
        logic [7:0] up;
        logic [2:0] res;
        up = ch & ~CASE_BIT;
        // lower case folds onto upper case only for letters
        if (ch == GAP_CHAR) begin
            res = KIND_MIS_OTHER[2:0];
        end else if (up == CHAR_A) begin
            res = KIND_MIS_A[2:0];
        end else if (up == CHAR_C) begin
            res = KIND_MIS_C[2:0];
        end else if (up == CHAR_G) begin
            res = KIND_MIS_G[2:0];
        end else if (up == CHAR_T) begin
            res = KIND_MIS_T[2:0];
        end else begin
            res = KIND_MIS_OTHER[2:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/alignment_error_profiler_core.sv
// Channel | Ports                               | Beat
// --------+-------------------------------------+-----------------------------------------
// input   | s_valid, s_ready, s_<field>          | one alignment column or counter request
// result  | m_valid, m_ready, m_count_value      | one counter value per counter request
// config  | psel, penable, pwrite, paddr, pwdata | APB register write/read, pready tied high
//
// One beat per cycle is accepted while s_ready is high; a counter request's value passes the
// stage-one registers and then the output queue. Counted column beats read-modify-write the
// totals memory and, if the read position is in range, the position counter memory: read on
// accept, increment and write back next cycle, with the last write forwarded when the
// following beat reads the same entry. After reset a clearing pass zeroes the memories,
// 64 * 2**clog2(POSITIONS) position entries (32768 at default), with s_ready low throughout;
// then s_ready drops only if the two-entry output queue absorbing m_ready stalls can fill.
module alignment_error_profiler_core #(
    parameter int POSITIONS    = aep_pkg::POSITIONS_DEF,
    parameter int COUNTER_BITS = aep_pkg::COUNTER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic        s_start_of_read,
    input  logic [7:0]  s_read_char,
    input  logic [7:0]  s_ref_char,
    input  logic [7:0]  s_map_quality,
    input  logic        s_unmapped,
    input  logic        s_second_in_pair,
    input  logic [3:0]  s_counter_kind,
    input  logic [1:0]  s_counter_bin,
    input  logic        s_counter_read,
    input  logic [8:0]  s_counter_position,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_count_value,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PAW = $clog2(POSITIONS) + 6;

    logic       aligned_mode_reg;
    logic [9:0] position_limit_reg;
    logic [7:0] low_bound_reg;
    logic [7:0] high_bound_reg;

    aep_pkg::reg_idx_t reg_idx;
    aep_pkg::req_t     req;
    logic [PAW-1:0]    pos_addr;
    logic [aep_pkg::TOT_AW-1:0] tot_addr;
    logic              clearing;
    logic              s1_read;
    logic              push;
    logic [31:0]       push_data;
    logic [1:0]        level;
    logic              accept;
    logic              pop;

    assign pready  = 1'b1;
    assign reg_idx = aep_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aligned_mode_reg   <= aep_pkg::ALIGNED_MODE_RST;
            position_limit_reg <= aep_pkg::POS_LIMIT_RST;
            low_bound_reg      <= aep_pkg::LOW_BOUND_RST;
            high_bound_reg     <= aep_pkg::HIGH_BOUND_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                aep_pkg::REG_ALIGNED_MODE: aligned_mode_reg   <= pwdata[0];
                aep_pkg::REG_POS_LIMIT:    position_limit_reg <= pwdata[9:0];
                aep_pkg::REG_LOW_BOUND:    low_bound_reg      <= pwdata[7:0];
                aep_pkg::REG_HIGH_BOUND:   high_bound_reg     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            aep_pkg::REG_ALIGNED_MODE: prdata = 32'(aligned_mode_reg);
            aep_pkg::REG_POS_LIMIT:    prdata = 32'(position_limit_reg);
            aep_pkg::REG_LOW_BOUND:    prdata = 32'(low_bound_reg);
            aep_pkg::REG_HIGH_BOUND:   prdata = 32'(high_bound_reg);
            default:                   prdata = '0;
        endcase
    end

    // hold off a beat unless the queue is sure to have room for its result
    assign pop     = m_valid && m_ready;
    assign s_ready = !clearing &&
                     (({1'b0, level} + {2'b0, s1_read}) <= (3'd1 + {2'b0, pop}));
    assign accept  = s_valid && s_ready;

    aep_column_ctl #(
        .POSITIONS (POSITIONS),
        .PAW       (PAW)
    ) u_ctl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .accept             (accept),
        .op                 (s_op),
        .start_of_read      (s_start_of_read),
        .read_char          (s_read_char),
        .ref_char           (s_ref_char),
        .map_quality        (s_map_quality),
        .unmapped           (s_unmapped),
        .second_in_pair     (s_second_in_pair),
        .counter_kind       (s_counter_kind),
        .counter_bin        (s_counter_bin),
        .counter_read       (s_counter_read),
        .counter_position   (s_counter_position),
        .aligned_mode       (aligned_mode_reg),
        .position_limit     (position_limit_reg),
        .low_quality_bound  (low_bound_reg),
        .high_quality_bound (high_bound_reg),
        .req                (req),
        .pos_addr           (pos_addr),
        .tot_addr           (tot_addr)
    );

    aep_counter_update #(
        .PAW          (PAW),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .pos_addr  (pos_addr),
        .tot_addr  (tot_addr),
        .clearing  (clearing),
        .s1_read   (s1_read),
        .push      (push),
        .push_data (push_data)
    );

    aep_out_fifo u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .push_data     (push_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_count_value (m_count_value),
        .level         (level)
    );

endmodule

FILE: rtl/aep_column_ctl.sv
module aep_column_ctl #(
    parameter int POSITIONS = aep_pkg::POSITIONS_DEF,
    parameter int PAW       = $clog2(POSITIONS) + 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic             op,
    input  logic             start_of_read,
    input  logic [7:0]       read_char,
    input  logic [7:0]       ref_char,
    input  logic [7:0]       map_quality,
    input  logic             unmapped,
    input  logic             second_in_pair,
    input  logic [3:0]       counter_kind,
    input  logic [1:0]       counter_bin,
    input  logic             counter_read,
    input  logic [8:0]       counter_position,
    input  logic             aligned_mode,
    input  logic [9:0]       position_limit,
    input  logic [7:0]       low_quality_bound,
    input  logic [7:0]       high_quality_bound,
    output aep_pkg::req_t    req,
    output logic [PAW-1:0]   pos_addr,
    output logic [aep_pkg::TOT_AW-1:0] tot_addr
);

    localparam int PB = PAW - 6;

    logic [1:0] bin_reg, bin_next;
    logic       rdsel_reg, rdsel_next;
    logic [9:0] col_reg, col_next;
    logic [9:0] rpos_reg, rpos_next;
    logic       prev_rgap_reg, prev_rgap_next;
    logic       prev_ggap_reg, prev_ggap_next;

    always_comb begin
        logic [1:0] bin_eff;
        logic       rd_eff;
        logic [9:0] col_eff;
        logic [9:0] rp_eff;
        logic       active;
        logic       rgap;
        logic       ggap;
        logic       pos_ok;
        logic       cpos_ok;
        logic [2:0] grp;
        logic [2:0] kind;
        logic [1:0] tslot;
        logic       hit;

        bin_next       = bin_reg;
        rdsel_next     = rdsel_reg;
        col_next       = col_reg;
        rpos_next      = rpos_reg;
        prev_rgap_next = prev_rgap_reg;
        prev_ggap_next = prev_ggap_reg;

        req      = '0;
        req.sel  = aep_pkg::SEL_ZERO;
        pos_addr = '0;
        tot_addr = '0;

        // sample bin and read at the start of a read
        if (map_quality < low_quality_bound) begin
            bin_eff = aep_pkg::BIN_LOW;
        end else if (map_quality < high_quality_bound) begin
            bin_eff = aep_pkg::BIN_MIDDLE;
        end else begin
            bin_eff = aep_pkg::BIN_HIGH;
        end
        if (unmapped) begin
            bin_eff = aep_pkg::BIN_UNMAPPED;
        end
        rd_eff  = second_in_pair;
        col_eff = '0;
        rp_eff  = '0;
        if (!start_of_read) begin
            bin_eff = bin_reg;
            rd_eff  = rdsel_reg;
            col_eff = col_reg;
            rp_eff  = rpos_reg;
        end

        active  = col_eff < position_limit;
        rgap    = read_char == aep_pkg::GAP_CHAR;
        ggap    = ref_char == aep_pkg::GAP_CHAR;
        pos_ok  = 32'(rp_eff) < 32'(POSITIONS);
        cpos_ok = 32'(counter_position) < 32'(POSITIONS);
        grp     = {bin_eff, rd_eff};
        kind    = aep_pkg::KIND_INS[2:0];
        tslot   = aep_pkg::TOT_INS;
        hit     = 1'b0;

        if (!rgap && ggap) begin
            hit = start_of_read || !prev_ggap_reg;
        end else if (rgap && !ggap) begin
            hit   = start_of_read || !prev_rgap_reg;
            kind  = aep_pkg::KIND_DEL[2:0];
            tslot = aep_pkg::TOT_DEL;
        end else if (!rgap && !ggap) begin
            hit   = read_char != ref_char;
            kind  = aep_pkg::base_class(read_char);
            tslot = aep_pkg::TOT_MIS;
        end

        if (op == aep_pkg::OP_COLUMN) begin
            req.vld    = accept && aligned_mode;
            req.pos_en = active && hit && pos_ok;
            req.tot_en = active && hit;
            pos_addr   = {kind, grp, PB'(rp_eff)};
            tot_addr   = {grp, tslot};
            if (accept && aligned_mode) begin
                if (start_of_read) begin
                    bin_next   = bin_eff;
                    rdsel_next = rd_eff;
                end
                col_next  = col_eff;
                rpos_next = rp_eff;
                if (active) begin
                    prev_rgap_next = rgap;
                    prev_ggap_next = ggap;
                    if (col_eff != aep_pkg::COLUMN_MAX) begin
                        col_next = col_eff + 10'd1;
                    end
                    if (!rgap) begin
                        rpos_next = rp_eff + 10'd1;
                    end
                end
            end
        end else begin
            req.vld  = accept;
            req.rd   = 1'b1;
            pos_addr = {counter_kind[2:0], counter_bin, counter_read, PB'(counter_position)};
            tot_addr = {counter_bin, counter_read, aep_pkg::TOT_MIS};
            case (counter_kind) inside
                [aep_pkg::KIND_MIS_A:aep_pkg::KIND_DEL]: begin
                    if (cpos_ok) begin
                        req.sel = aep_pkg::SEL_POS;
                    end
                end
                aep_pkg::KIND_TOT_MIS: begin
                    req.sel = aep_pkg::SEL_TOT;
                end
                aep_pkg::KIND_TOT_INS: begin
                    req.sel  = aep_pkg::SEL_TOT;
                    tot_addr = {counter_bin, counter_read, aep_pkg::TOT_INS};
                end
                aep_pkg::KIND_TOT_DEL: begin
                    req.sel  = aep_pkg::SEL_TOT;
                    tot_addr = {counter_bin, counter_read, aep_pkg::TOT_DEL};
                end
                default: begin
                    req.sel = aep_pkg::SEL_ZERO;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg       <= aep_pkg::BIN_UNMAPPED;
            rdsel_reg     <= 1'b0;
            col_reg       <= '0;
            rpos_reg      <= '0;
            prev_rgap_reg <= 1'b0;
            prev_ggap_reg <= 1'b0;
        end else begin
            bin_reg       <= bin_next;
            rdsel_reg     <= rdsel_next;
            col_reg       <= col_next;
            rpos_reg      <= rpos_next;
            prev_rgap_reg <= prev_rgap_next;
            prev_ggap_reg <= prev_ggap_next;
        end
    end

endmodule

FILE: rtl/aep_counter_update.sv
module aep_counter_update #(
    parameter int PAW          = $clog2(aep_pkg::POSITIONS_DEF) + 6,
    parameter int COUNTER_BITS = aep_pkg::COUNTER_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  aep_pkg::req_t    req,
    input  logic [PAW-1:0]   pos_addr,
    input  logic [aep_pkg::TOT_AW-1:0] tot_addr,
    output logic             clearing,
    output logic             s1_read,
    output logic             push,
    output logic [31:0]      push_data
);

    localparam int TAW = aep_pkg::TOT_AW;
    localparam int CB  = COUNTER_BITS;

    logic [CB-1:0] pos_mem [2**PAW];
    logic [CB-1:0] tot_mem [2**TAW];
    logic [CB-1:0] pos_q;
    logic [CB-1:0] tot_q;

    aep_pkg::req_t  s1_req_reg;
    logic [PAW-1:0] s1_pos_addr_reg;
    logic [TAW-1:0] s1_tot_addr_reg;

    logic           clr_active_reg, clr_active_next;
    logic [PAW-1:0] clr_addr_reg, clr_addr_next;

    logic           fw_pos_vld_reg, fw_tot_vld_reg;
    logic [PAW-1:0] fw_pos_addr_reg;
    logic [TAW-1:0] fw_tot_addr_reg;
    logic [CB-1:0]  fw_pos_data_reg, fw_tot_data_reg;

    logic [CB-1:0]  pos_cur, tot_cur, sel_val;
    logic           pos_we, tot_we;
    logic [PAW-1:0] pos_wa;
    logic [TAW-1:0] tot_wa;
    logic [CB-1:0]  pos_wd, tot_wd;

    // take the last write when it hit the entry read in the same cycle
    assign pos_cur = (fw_pos_vld_reg && fw_pos_addr_reg == s1_pos_addr_reg)
                     ? fw_pos_data_reg : pos_q;
    assign tot_cur = (fw_tot_vld_reg && fw_tot_addr_reg == s1_tot_addr_reg)
                     ? fw_tot_data_reg : tot_q;

    always_comb begin
        pos_we = 1'b0;
        tot_we = 1'b0;
        pos_wa = s1_pos_addr_reg;
        tot_wa = s1_tot_addr_reg;
        pos_wd = (pos_cur == {CB{1'b1}}) ? pos_cur : pos_cur + CB'(1);
        tot_wd = (tot_cur == {CB{1'b1}}) ? tot_cur : tot_cur + CB'(1);
        if (clr_active_reg) begin
            pos_we = 1'b1;
            tot_we = clr_addr_reg[PAW-1:TAW] == '0;
            pos_wa = clr_addr_reg;
            tot_wa = clr_addr_reg[TAW-1:0];
            pos_wd = '0;
            tot_wd = '0;
        end else if (s1_req_reg.vld && !s1_req_reg.rd) begin
            pos_we = s1_req_reg.pos_en;
            tot_we = s1_req_reg.tot_en;
        end
    end

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + PAW'(1);
            if (clr_addr_reg == {PAW{1'b1}}) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (req.vld) begin
            pos_q <= pos_mem[pos_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (tot_we) begin
            tot_mem[tot_wa] <= tot_wd;
        end
        if (req.vld) begin
            tot_q <= tot_mem[tot_addr];
        end
    end

    always_ff @(posedge aclk) begin
        s1_pos_addr_reg <= pos_addr;
        s1_tot_addr_reg <= tot_addr;
        if (pos_we) begin
            fw_pos_addr_reg <= pos_wa;
            fw_pos_data_reg <= pos_wd;
        end
        if (tot_we) begin
            fw_tot_addr_reg <= tot_wa;
            fw_tot_data_reg <= tot_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_req_reg     <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fw_pos_vld_reg <= 1'b0;
            fw_tot_vld_reg <= 1'b0;
        end else begin
            s1_req_reg     <= req;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            if (pos_we) begin
                fw_pos_vld_reg <= 1'b1;
            end
            if (tot_we) begin
                fw_tot_vld_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        case (s1_req_reg.sel)
            aep_pkg::SEL_POS: sel_val = pos_cur;
            aep_pkg::SEL_TOT: sel_val = tot_cur;
            default:          sel_val = '0;
        endcase
    end

    generate
        if (CB > 32) begin : g_sat
            assign push_data = (|sel_val[CB-1:32]) ? 32'hFFFF_FFFF : sel_val[31:0];
        end else begin : g_ext
            assign push_data = 32'(sel_val);
        end
    endgenerate

    assign clearing = clr_active_reg;
    assign s1_read  = s1_req_reg.vld && s1_req_reg.rd;
    assign push     = s1_read;

endmodule

FILE: rtl/aep_out_fifo.sv
module aep_out_fifo (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  logic [31:0] push_data,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [31:0] m_count_value,
    output logic [1:0]  level
);

    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] d0_reg, d0_next;
    logic [31:0] d1_reg, d1_next;
    logic        pop;

    assign pop = (cnt_reg != 2'd0) && m_ready;

    always_comb begin
        logic [1:0] slot;
        d0_next = d0_reg;
        d1_next = d1_reg;
        slot    = cnt_reg - {1'b0, pop};
        if (pop) begin
            d0_next = d1_reg;
        end
        if (push) begin
            if (slot == 2'd0) begin
                d0_next = push_data;
            end else begin
                d1_next = push_data;
            end
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign m_valid       = cnt_reg != 2'd0;
    assign m_count_value = d0_reg;
    assign level         = cnt_reg;

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aep_pkg::*;

    localparam int POS_N           = POSITIONS_DEF;
    localparam int GRP_N           = 8;
    localparam int BASE_N          = 5;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RUN_LIMIT_NS    = 10_000_000;

    localparam logic [7:0] CHAR_N         = 8'd78;
    localparam logic [3:0] KIND_UNUSED_LO = 4'd10;
    localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

    typedef struct {
        logic       op;
        logic       start;
        logic [7:0] read_char;
        logic [7:0] ref_char;
        logic [7:0] map_q;
        logic       unm;
        logic       second;
        logic [3:0] kind;
        logic [1:0] bin;
        logic       rd;
        logic [8:0] pos;
    } beat_t;

    // Error profile predictor plus the queue of counter values still owed by the block
    class profile_scoreboard;
        bit          aligned_on;
        logic [9:0]  pos_limit;
        logic [7:0]  low_bound;
        logic [7:0]  high_bound;
        int          col_idx;
        int          rd_pos;
        bit          prev_read_gap;
        bit          prev_ref_gap;
        logic [1:0]  cur_bin;
        bit          cur_read;
        logic [31:0] mis_cnt [BASE_N*GRP_N*POS_N];
        logic [31:0] ins_cnt [GRP_N*POS_N];
        logic [31:0] del_cnt [GRP_N*POS_N];
        logic [31:0] tot_cnt [GRP_N*3];
        logic [31:0] awaited_counts [$];
        int          errors;

        function new();
            aligned_on    = ALIGNED_MODE_RST;
            pos_limit     = POS_LIMIT_RST;
            low_bound     = LOW_BOUND_RST;
            high_bound    = HIGH_BOUND_RST;
            col_idx       = 0;
            rd_pos        = 0;
            prev_read_gap = 1'b0;
            prev_ref_gap  = 1'b0;
            cur_bin       = BIN_UNMAPPED;
            cur_read      = 1'b0;
            foreach (mis_cnt[i]) mis_cnt[i] = '0;
            foreach (ins_cnt[i]) ins_cnt[i] = '0;
            foreach (del_cnt[i]) del_cnt[i] = '0;
            foreach (tot_cnt[i]) tot_cnt[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_ALIGNED_MODE: aligned_on = val[0];
                REG_POS_LIMIT:    pos_limit  = val[9:0];
                REG_LOW_BOUND:    low_bound  = val[7:0];
                REG_HIGH_BOUND:   high_bound = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] bumped(logic [31:0] c);
            return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
        endfunction

        function logic [3:0] base_of(logic [7:0] ch);
            case (ch)
                CHAR_A, CHAR_A | CASE_BIT: return KIND_MIS_A;
                CHAR_C, CHAR_C | CASE_BIT: return KIND_MIS_C;
                CHAR_G, CHAR_G | CASE_BIT: return KIND_MIS_G;
                CHAR_T, CHAR_T | CASE_BIT: return KIND_MIS_T;
                default:                   return KIND_MIS_OTHER;
            endcase
        endfunction

        function void count_column(beat_t b);
            bit rgap;
            bit ggap;
            bit pos_ok;
            int grp;
            int pidx;
            rgap   = (b.read_char == GAP_CHAR);
            ggap   = (b.ref_char == GAP_CHAR);
            grp    = int'(cur_bin) * 2 + int'(cur_read);
            pos_ok = (rd_pos < POS_N);
            pidx   = grp * POS_N + (pos_ok ? rd_pos : 0);
            if (!rgap && ggap) begin
                // only the first column of an insertion run counts
                if (b.start || !prev_ref_gap) begin
                    if (pos_ok) ins_cnt[pidx] = bumped(ins_cnt[pidx]);
                    tot_cnt[grp*3 + TOT_INS] = bumped(tot_cnt[grp*3 + TOT_INS]);
                end
                rd_pos++;
            end else if (rgap && !ggap) begin
                if (b.start || !prev_read_gap) begin
                    if (pos_ok) del_cnt[pidx] = bumped(del_cnt[pidx]);
                    tot_cnt[grp*3 + TOT_DEL] = bumped(tot_cnt[grp*3 + TOT_DEL]);
                end
            end else if (!rgap && !ggap) begin
                if (b.read_char != b.ref_char) begin
                    pidx += int'(base_of(b.read_char)) * GRP_N * POS_N;
                    if (pos_ok) mis_cnt[pidx] = bumped(mis_cnt[pidx]);
                    tot_cnt[grp*3 + TOT_MIS] = bumped(tot_cnt[grp*3 + TOT_MIS]);
                end
                rd_pos++;
            end
        endfunction

        function void note_beat(beat_t b);
            int          grp;
            int          pidx;
            logic [31:0] v;
            if (b.op == OP_READ) begin
                grp  = int'(b.bin) * 2 + int'(b.rd);
                pidx = grp * POS_N + int'(b.pos);
                v    = '0;
                if (b.kind <= KIND_MIS_OTHER) begin
                    v = mis_cnt[int'(b.kind) * GRP_N * POS_N + pidx];
                end else if (b.kind == KIND_INS) begin
                    v = ins_cnt[pidx];
                end else if (b.kind == KIND_DEL) begin
                    v = del_cnt[pidx];
                end else if (b.kind <= KIND_TOT_DEL) begin
                    v = tot_cnt[grp*3 + int'(b.kind) - int'(KIND_TOT_MIS)];
                end
                awaited_counts.push_back(v);
                return;
            end
            if (!aligned_on) return;
            if (b.start) begin
                if (b.unm) begin
                    cur_bin = BIN_UNMAPPED;
                end else if (b.map_q < low_bound) begin
                    cur_bin = BIN_LOW;
                end else if (b.map_q < high_bound) begin
                    cur_bin = BIN_MIDDLE;
                end else begin
                    cur_bin = BIN_HIGH;
                end
                cur_read = b.second;
                col_idx  = 0;
                rd_pos   = 0;
            end
            if (col_idx < int'(pos_limit)) begin
                count_column(b);
                prev_read_gap = (b.read_char == GAP_CHAR);
                prev_ref_gap  = (b.ref_char == GAP_CHAR);
                if (col_idx < int'(COLUMN_MAX)) col_idx++;
            end
        endfunction

        function void check_count(logic [31:0] got);
            logic [31:0] want;
            if (awaited_counts.size() == 0) begin
                errors++;
                $error("count_value: expected nothing, got %0d", got);
                return;
            end
            want = awaited_counts.pop_front();
            if (got !== want) begin
                errors++;
                $error("count_value: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic        s_start_of_read;
    logic [7:0]  s_read_char;
    logic [7:0]  s_ref_char;
    logic [7:0]  s_map_quality;
    logic        s_unmapped;
    logic        s_second_in_pair;
    logic [3:0]  s_counter_kind;
    logic [1:0]  s_counter_bin;
    logic        s_counter_read;
    logic [8:0]  s_counter_position;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_count_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    profile_scoreboard sb;
    bit src_idle_en;
    bit sink_idle_en;
    bit hold_off_req;
    bit reset_done;

    alignment_error_profiler_core u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_start_of_read    (s_start_of_read),
        .s_read_char        (s_read_char),
        .s_ref_char         (s_ref_char),
        .s_map_quality      (s_map_quality),
        .s_unmapped         (s_unmapped),
        .s_second_in_pair   (s_second_in_pair),
        .s_counter_kind     (s_counter_kind),
        .s_counter_bin      (s_counter_bin),
        .s_counter_read     (s_counter_read),
        .s_counter_position (s_counter_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_count_value      (m_count_value),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [7:0] base_char();
        case ($urandom_range(0, 3))
            0:       return CHAR_A;
            1:       return CHAR_C;
            2:       return CHAR_G;
            default: return CHAR_T;
        endcase
    endfunction

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 7))
            0, 1:    return GAP_CHAR;
            2, 3, 4: return base_char();
            5:       return base_char() | CASE_BIT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Lean on the bin boundaries of the current setting
    function automatic logic [7:0] pick_quality();
        case ($urandom_range(0, 7))
            0:       return sb.low_bound - 8'd1;
            1:       return sb.low_bound;
            2:       return sb.high_bound - 8'd1;
            3:       return sb.high_bound;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic beat_t column_beat(input bit start, input logic [7:0] rc, gc, q,
                                          input bit unm, second);
        beat_t b;
        b.op        = OP_COLUMN;
        b.start     = start;
        b.read_char = rc;
        b.ref_char  = gc;
        b.map_q     = q;
        b.unm       = unm;
        b.second    = second;
        b.kind      = 4'($urandom_range(0, 15));
        b.bin       = 2'($urandom_range(0, 3));
        b.rd        = 1'($urandom_range(0, 1));
        b.pos       = 9'($urandom_range(0, 511));
        return b;
    endfunction

    function automatic beat_t request_beat(input logic [3:0] kind, input logic [1:0] bin,
                                           input bit rd, input logic [8:0] pos);
        beat_t b;
        b.op        = OP_READ;
        b.start     = 1'($urandom_range(0, 1));
        b.read_char = 8'($urandom_range(0, 255));
        b.ref_char  = 8'($urandom_range(0, 255));
        b.map_q     = 8'($urandom_range(0, 255));
        b.unm       = 1'($urandom_range(0, 1));
        b.second    = 1'($urandom_range(0, 1));
        b.kind      = kind;
        b.bin       = bin;
        b.rd        = rd;
        b.pos       = pos;
        return b;
    endfunction

    task automatic send_beat(beat_t b);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_op               <= b.op;
        s_start_of_read    <= b.start;
        s_read_char        <= b.read_char;
        s_ref_char         <= b.ref_char;
        s_map_quality      <= b.map_q;
        s_unmapped         <= b.unm;
        s_second_in_pair   <= b.second;
        s_counter_kind     <= b.kind;
        s_counter_bin      <= b.bin;
        s_counter_read     <= b.rd;
        s_counter_position <= b.pos;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_beat(b);
    endtask

    // Drop valid, wait for every owed count, then let trailing columns retire
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.awaited_counts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(bit mode, logic [9:0] limit, logic [7:0] low, logic [7:0] high);
        settle();
        apb_write(REG_ALIGNED_MODE, {31'd0, mode});
        apb_write(REG_POS_LIMIT, {22'd0, limit});
        apb_write(REG_LOW_BOUND, {24'd0, low});
        apb_write(REG_HIGH_BOUND, {24'd0, high});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_read(int len, bit with_start, bit dense);
        logic [7:0] rc;
        logic [7:0] gc;
        for (int i = 0; i < len; i++) begin
            if (dense) begin
                // no gaps: every column advances the read position
                rc = base_char();
                gc = ($urandom_range(0, 3) == 0) ? base_char() : rc;
            end else begin
                rc = rand_char();
                gc = ($urandom_range(0, 1) == 0) ? rc : rand_char();
            end
            send_beat(column_beat(with_start && i == 0, rc, gc, pick_quality(),
                                  $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic send_requests(int n);
        logic [3:0] kind;
        logic [8:0] pos;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            end else begin
                kind = 4'($urandom_range(KIND_MIS_A, KIND_TOT_DEL));
            end
            pos = ($urandom_range(0, 3) != 0) ? 9'($urandom_range(0, 31))
                                              : 9'($urandom_range(0, 511));
            send_beat(request_beat(kind, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                   pos));
        end
    endtask

    task automatic random_traffic(int n);
        int done_n;
        int len;
        int pick;
        done_n = 0;
        while (done_n < n) begin
            pick = $urandom_range(0, 11);
            if (pick < 6) begin
                len = $urandom_range(1, 24);
                send_read(len, 1'b1, 1'b0);
            end else if (pick == 6) begin
                // continuation with no start of read
                len = $urandom_range(1, 6);
                send_read(len, 1'b0, 1'b0);
            end else begin
                len = $urandom_range(1, 4);
                send_requests(len);
            end
            done_n += len;
        end
    endtask

    task automatic directed();
        // columns ahead of any start land in the unmapped bin, first read
        send_beat(column_beat(1'b0, CHAR_A, CHAR_A, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b0, CHAR_C, CHAR_G, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b0, CHAR_T, GAP_CHAR, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b0, CHAR_G, GAP_CHAR, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b0, GAP_CHAR, GAP_CHAR, 8'd0, 1'b0, 1'b0));
        // unmapped wins over high quality; first column opens a fresh insertion
        send_beat(column_beat(1'b1, CHAR_A, GAP_CHAR, 8'd255, 1'b1, 1'b0));
        send_beat(column_beat(1'b0, GAP_CHAR, CHAR_A, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b0, GAP_CHAR, CHAR_C, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b0, CHAR_A | CASE_BIT, CHAR_A, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b0, CHAR_N, CHAR_A, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b0, 8'hFF, 8'h00, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b1, GAP_CHAR, CHAR_G, 8'd0, 1'b0, 1'b1));
        send_beat(column_beat(1'b0, CHAR_T | CASE_BIT, CHAR_G | CASE_BIT, 8'd0, 1'b0, 1'b0));
        send_beat(column_beat(1'b1, CHAR_G | CASE_BIT, CHAR_C, 8'd9, 1'b0, 1'b0));
        send_beat(column_beat(1'b1, CHAR_C | CASE_BIT, CHAR_A, 8'd10, 1'b0, 1'b1));
        send_beat(column_beat(1'b1, CHAR_T, CHAR_A, 8'd29, 1'b0, 1'b0));
        send_beat(column_beat(1'b1, CHAR_G, CHAR_A, 8'd30, 1'b0, 1'b1));
        send_beat(request_beat(KIND_MIS_C, BIN_UNMAPPED, 1'b0, 9'd1));
        send_beat(request_beat(KIND_INS, BIN_UNMAPPED, 1'b0, 9'd2));
        send_beat(request_beat(KIND_INS, BIN_UNMAPPED, 1'b0, 9'd0));
        send_beat(request_beat(KIND_DEL, BIN_UNMAPPED, 1'b0, 9'd1));
        send_beat(request_beat(KIND_MIS_A, BIN_UNMAPPED, 1'b0, 9'd1));
        send_beat(request_beat(KIND_MIS_OTHER, BIN_UNMAPPED, 1'b0, 9'd3));
        for (logic [3:0] k = KIND_TOT_MIS; k <= KIND_TOT_DEL; k++) begin
            send_beat(request_beat(k, BIN_UNMAPPED, 1'b0, 9'd0));
        end
        send_beat(request_beat(KIND_MIS_T, BIN_LOW, 1'b1, 9'd0));
        send_beat(request_beat(KIND_MIS_G, BIN_LOW, 1'b0, 9'd0));
        send_beat(request_beat(KIND_UNUSED_HI, BIN_MIDDLE, 1'b1, 9'd0));
        send_beat(request_beat(KIND_UNUSED_LO, BIN_HIGH, 1'b1, 9'd0));
        send_beat(request_beat(KIND_MIS_G, BIN_HIGH, 1'b1, 9'd511));
    endtask

    initial begin : result_sink
        int stall;
        wait (reset_done);
        forever begin
            if (hold_off_req) begin
                stall        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                stall = sink_idle_en ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_count(m_count_value);
        end
    end

    initial begin : stimulus
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_op               <= OP_COLUMN;
        s_start_of_read    <= 1'b0;
        s_read_char        <= '0;
        s_ref_char         <= '0;
        s_map_quality      <= '0;
        s_unmapped         <= 1'b0;
        s_second_in_pair   <= 1'b0;
        s_counter_kind     <= KIND_MIS_A;
        s_counter_bin      <= BIN_LOW;
        s_counter_read     <= 1'b0;
        s_counter_position <= '0;
        m_ready            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        sb           = new();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_off_req = 1'b0;
        reset_done   = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn    <= 1'b1;
        reset_done = 1'b1;

        configure(ALIGNED_MODE_RST, POS_LIMIT_RST, LOW_BOUND_RST, HIGH_BOUND_RST);
        directed();
        random_traffic(60);
        // stall the sink while requests keep coming so the output side backs up
        hold_off_req = 1'b1;
        send_requests(24);
        random_traffic(60);

        configure(1'b0, POS_LIMIT_RST, LOW_BOUND_RST, HIGH_BOUND_RST);
        random_traffic(30);
        configure(1'b1, 10'd1, 8'd0, 8'd255);
        random_traffic(80);
        configure(1'b1, 10'd0, 8'd255, 8'd0);
        random_traffic(30);

        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        configure(1'b1, 10'd512, 8'd128, 8'd64);
        random_traffic(80);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        random_traffic(40);

        // a dense read, then the top positions of its group and every total
        configure(1'b1, 10'd1023, 8'd0, 8'd0);
        send_read(24, 1'b1, 1'b1);
        for (int p = POS_N - 12; p < POS_N; p++) begin
            send_beat(request_beat(4'($urandom_range(KIND_MIS_A, KIND_DEL)), sb.cur_bin,
                                   sb.cur_read, 9'(p)));
        end
        for (int g = 0; g < GRP_N; g++) begin
            for (logic [3:0] k = KIND_TOT_MIS; k <= KIND_TOT_DEL; k++) begin
                send_beat(request_beat(k, 2'(g / 2), 1'(g % 2), 9'($urandom_range(0, 511))));
            end
        end
        random_traffic(30);

        settle();
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("tb: done, errors");
        $finish;
    end

endmodule
